>>> hw/rtl/adll_pkg.sv
// shared types and constants of the array doubly linked list
`timescale 1ns / 1ps

package adll_pkg;

    // payload field widths
    localparam int REQ_W    = 3;
    localparam int RANK_W   = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // rank plus one, wide enough to hold the slot of the highest rank
    localparam int RSLOT_W  = RANK_W + 1;

    // request codes
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INS_LEFT   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_INS_RIGHT  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ_OUT   = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DEAD  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // sentinel slots and first slot handed out
    localparam int HEAD_SLOT  = 0;
    localparam int TAIL_SLOT  = 1;
    localparam int FIRST_FREE = 2;

    // controller to datapath
    typedef struct packed {
        logic                latch;       // take the input item
        logic                rd_en;       // read the slot memories
        logic                rd_follow;   // read at the right link just read
        logic                link1;       // write the fresh node
        logic                link2;       // hook neighbors to the fresh node
        logic                del;         // unhook the addressed node
        logic                out_load;    // load the result register
        logic [STATUS_W-1:0] out_status;
        logic                out_use_value;
        logic                out_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             live;       // addressed node exists and is alive
        logic             full;       // no free slot left
        logic             ptr_tail;   // walk pointer sits on the tail sentinel
        logic             walk_last;  // node just read is the last before the tail
        logic             out_free;   // result register can take a result
    } t_sts;

endpackage

>>> hw/rtl/adll_if.sv
// request and result channel interfaces
`timescale 1ns / 1ps

interface adll_req_if;
    import adll_pkg::*;

    logic                       valid;
    logic                       ready;
    logic        [REQ_W-1:0]    req_type;
    logic        [RANK_W-1:0]   node_rank;
    logic signed [VALUE_W-1:0]  item_value;

    modport source (output valid, req_type, node_rank, item_value, input ready);
    modport sink   (input valid, req_type, node_rank, item_value, output ready);
endinterface

interface adll_res_if;
    import adll_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [VALUE_W-1:0]   read_value;
    logic        [STATUS_W-1:0]  status;
    logic                        last;

    modport source (output valid, read_value, status, last, input ready);
    modport sink   (input valid, read_value, status, last, output ready);
endinterface

>>> hw/rtl/array_doubly_linked_list_top.sv
// top level of the array doubly linked list
`timescale 1ns / 1ps

// channel       dir  handshake      payload
// i_req_chan    in   valid/ready    req_type, node_rank, item_value
// o_res_chan    out  valid/ready    read_value, status, last
//
// push and insert run accept, link read, fresh node write and neighbor write, then load the
// result; delete and rejected requests load it after the link read, an empty read out after
// accept; read out loads one element per cycle while the result register is free, set by the
// registered read of the right-link and value memories along the chain
// synchronous active-low reset; the sentinel links sit in registers, so no clearing pass
// a stalled result register holds the controller; a new item is taken only when idle

module array_doubly_linked_list_top import adll_pkg::*; #(
    parameter int SLOT_COUNT  = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    adll_req_if.sink   i_req_chan,
    adll_res_if.source o_res_chan
);

    t_cmd w_cmd;
    t_sts w_sts;

    // request sequencing, one item in flight
    adll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req_chan.valid),
        .i_req_type (i_req_chan.req_type),
        .o_in_ready (i_req_chan.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // slot memories, link registers and result register
    adll_dp #(
        .SLOT_COUNT  (SLOT_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_type   (i_req_chan.req_type),
        .i_node_rank  (i_req_chan.node_rank),
        .i_item_value (i_req_chan.item_value),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (o_res_chan.valid),
        .i_out_ready  (o_res_chan.ready),
        .o_read_value (o_res_chan.read_value),
        .o_status     (o_res_chan.status),
        .o_last       (o_res_chan.last)
    );

endmodule

>>> hw/rtl/adll_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module adll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/adll_dp.sv
// datapath: slot memories, sentinel links, allocation counter, result register
`timescale 1ns / 1ps

module adll_dp import adll_pkg::*; #(
    parameter int SLOT_COUNT  = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic        [REQ_W-1:0]    i_req_type,
    input  logic        [RANK_W-1:0]   i_node_rank,
    input  logic signed [VALUE_W-1:0]  i_item_value,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [VALUE_W-1:0]  o_read_value,
    output logic        [STATUS_W-1:0] o_status,
    output logic                       o_last
);

    localparam int AW = $clog2(SLOT_COUNT);
    localparam int NW = $clog2(SLOT_COUNT + 1);
    localparam logic [AW-1:0] HEAD = AW'(HEAD_SLOT);
    localparam logic [AW-1:0] TAIL = AW'(TAIL_SLOT);

    logic        [REQ_W-1:0]    r_req;
    logic signed [VALUE_W-1:0]  r_value;
    logic        [AW-1:0]       r_ptr;
    logic                       r_in_range;
    logic        [AW-1:0]       r_anchor;
    logic        [AW-1:0]       r_nxt;
    logic        [NW-1:0]       r_next_free;
    logic        [AW-1:0]       r_head_right;
    logic        [AW-1:0]       r_tail_left;
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_read_value;
    logic        [STATUS_W-1:0] r_status;
    logic                       r_last;

    logic [RSLOT_W-1:0]     w_slot;
    logic                   w_slot_ok;
    logic [AW-1:0]          w_fresh;
    logic [AW-1:0]          w_anchor;
    logic [AW-1:0]          w_nxt;
    logic [AW-1:0]          w_raddr;
    logic [AW-1:0]          w_left_q;
    logic [AW-1:0]          w_right_q;
    logic [VALUE_W-1:0]     w_value_q;
    logic                   w_alive_q;
    logic [63:0]            w_in_wide;
    logic [63:0]            w_out_wide;
    logic                   w_out_free;

    logic                   w_right_we;
    logic [AW-1:0]          w_right_waddr;
    logic [AW-1:0]          w_right_wdata;
    logic                   w_left_we;
    logic [AW-1:0]          w_left_waddr;
    logic [AW-1:0]          w_left_wdata;
    logic                   w_alive_we;
    logic [AW-1:0]          w_alive_waddr;
    logic                   w_alive_wdata;

    // slot of the addressed rank and its range test against the allocation front
    assign w_slot    = RSLOT_W'(i_node_rank) + RSLOT_W'(1);
    assign w_slot_ok = (32'(w_slot) >= 32'(FIRST_FREE)) && (32'(w_slot) < 32'(SLOT_COUNT))
                       && (32'(w_slot) < 32'(r_next_free));
    assign w_fresh   = AW'(r_next_free);
    assign w_raddr   = i_cmd.rd_follow ? w_right_q : r_ptr;

    always_comb begin
        case (r_req)
            REQ_PUSH_FRONT: begin
                w_anchor = HEAD;
                w_nxt    = r_head_right;
            end
            REQ_PUSH_BACK: begin
                w_anchor = r_tail_left;
                w_nxt    = TAIL;
            end
            REQ_INS_LEFT: begin
                w_anchor = w_left_q;
                w_nxt    = r_ptr;
            end
            default: begin
                w_anchor = r_ptr;
                w_nxt    = w_right_q;
            end
        endcase
    end

    // write port steering; sentinel-side links live in registers
    always_comb begin
        w_right_we    = 1'b0;
        w_right_waddr = w_fresh;
        w_right_wdata = w_nxt;
        w_left_we     = 1'b0;
        w_left_waddr  = w_fresh;
        w_left_wdata  = w_anchor;
        w_alive_we    = 1'b0;
        w_alive_waddr = w_fresh;
        w_alive_wdata = 1'b1;
        if (i_cmd.link1) begin
            w_right_we = 1'b1;
            w_left_we  = 1'b1;
            w_alive_we = 1'b1;
        end else if (i_cmd.link2) begin
            w_right_we    = (r_anchor != HEAD);
            w_right_waddr = r_anchor;
            w_right_wdata = w_fresh;
            w_left_we     = (r_nxt != TAIL);
            w_left_waddr  = r_nxt;
            w_left_wdata  = w_fresh;
        end else if (i_cmd.del) begin
            w_right_we    = (w_left_q != HEAD);
            w_right_waddr = w_left_q;
            w_right_wdata = w_right_q;
            w_left_we     = (w_right_q != TAIL);
            w_left_waddr  = w_right_q;
            w_left_wdata  = w_left_q;
            w_alive_we    = 1'b1;
            w_alive_waddr = r_ptr;
            w_alive_wdata = 1'b0;
        end
    end

    assign w_in_wide = 64'($unsigned(r_value));

    adll_ram #(.WIDTH(VALUE_W), .DEPTH(SLOT_COUNT)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.link1),
        .i_waddr (w_fresh),
        .i_wdata (w_in_wide[VALUE_W-1:0]),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_value_q)
    );

    adll_ram #(.WIDTH(AW), .DEPTH(SLOT_COUNT)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (w_right_we),
        .i_waddr (w_right_waddr),
        .i_wdata (w_right_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_right_q)
    );

    adll_ram #(.WIDTH(AW), .DEPTH(SLOT_COUNT)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (w_left_we),
        .i_waddr (w_left_waddr),
        .i_wdata (w_left_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_left_q)
    );

    // reads above the allocation front are masked by the range test, so never-written entries do not matter
    adll_ram #(.WIDTH(1), .DEPTH(SLOT_COUNT)) u_alive_ram (
        .i_clk   (i_clk),
        .i_we    (w_alive_we),
        .i_waddr (w_alive_waddr),
        .i_wdata (w_alive_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_alive_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req      <= i_req_type;
            r_value    <= i_item_value;
            r_in_range <= w_slot_ok;
            r_ptr      <= (i_req_type == REQ_READ_OUT) ? r_head_right : AW'(w_slot);
        end else if (i_cmd.rd_en && i_cmd.rd_follow) begin
            r_ptr <= w_right_q;
        end
        if (i_cmd.link1) begin
            r_anchor <= w_anchor;
            r_nxt    <= w_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free  <= NW'(FIRST_FREE);
            r_head_right <= TAIL;
            r_tail_left  <= HEAD;
        end else begin
            if (i_cmd.link2) begin
                r_next_free <= r_next_free + NW'(1);
                if (r_anchor == HEAD) begin
                    r_head_right <= w_fresh;
                end
                if (r_nxt == TAIL) begin
                    r_tail_left <= w_fresh;
                end
            end else if (i_cmd.del) begin
                if (w_left_q == HEAD) begin
                    r_head_right <= w_right_q;
                end
                if (w_right_q == TAIL) begin
                    r_tail_left <= w_left_q;
                end
            end
        end
    end

    // result register
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_wide = 64'(w_value_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_read_value <= i_cmd.out_use_value ? $signed(w_out_wide[VALUE_W-1:0]) : '0;
            r_status     <= i_cmd.out_status;
            r_last       <= i_cmd.out_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_last       = r_last;

    assign o_sts.req       = r_req;
    assign o_sts.live      = r_in_range && w_alive_q;
    assign o_sts.full      = (r_next_free == NW'(SLOT_COUNT));
    assign o_sts.ptr_tail  = (r_ptr == TAIL);
    assign o_sts.walk_last = (w_right_q == TAIL);
    assign o_sts.out_free  = w_out_free;

endmodule

>>> hw/rtl/adll_ctrl.sv
// controller: request sequencing and read-out walk
`timescale 1ns / 1ps

module adll_ctrl import adll_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [REQ_W-1:0] i_req_type,
    output logic             o_in_ready,
    input  t_sts             i_sts,
    output t_cmd             o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_LINK2  = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;
    localparam logic [2:0] S_WSTART = 3'd5;
    localparam logic [2:0] S_WALK   = 3'd6;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [STATUS_W-1:0] r_pend;
    logic [STATUS_W-1:0] n_pend;
    logic                w_finish;
    logic [STATUS_W-1:0] w_fin_status;

    always_comb begin
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        n_state      = r_state;
        n_pend       = r_pend;
        w_finish     = 1'b0;
        w_fin_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    unique case (i_req_type) inside
                        REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_DELETE,
                        REQ_INS_LEFT, REQ_INS_RIGHT: n_state = S_LOOK;
                        REQ_READ_OUT:                n_state = S_WSTART;
                        default:                     n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOK: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                if ((i_sts.req == REQ_DELETE || i_sts.req == REQ_INS_LEFT ||
                     i_sts.req == REQ_INS_RIGHT) && !i_sts.live) begin
                    w_finish     = 1'b1;
                    w_fin_status = ST_DEAD;
                end else if (i_sts.req == REQ_DELETE) begin
                    o_cmd.del = 1'b1;
                    w_finish  = 1'b1;
                end else if (i_sts.full) begin
                    w_finish     = 1'b1;
                    w_fin_status = ST_FULL;
                end else begin
                    o_cmd.link1 = 1'b1;
                    n_state     = S_LINK2;
                end
            end
            S_LINK2: begin
                o_cmd.link2 = 1'b1;
                w_finish    = 1'b1;
            end
            S_RESP: begin
                w_finish     = 1'b1;
                w_fin_status = r_pend;
            end
            S_WSTART: begin
                if (i_sts.ptr_tail) begin
                    w_finish     = 1'b1;
                    w_fin_status = ST_EMPTY;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load      = 1'b1;
                    o_cmd.out_use_value = 1'b1;
                    o_cmd.out_status    = ST_OK;
                    o_cmd.out_last      = i_sts.walk_last;
                    if (i_sts.walk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_en     = 1'b1;
                        o_cmd.rd_follow = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // single result of a request: load now or park it until the output frees
        if (w_finish) begin
            if (i_sts.out_free) begin
                o_cmd.out_load   = 1'b1;
                o_cmd.out_status = w_fin_status;
                o_cmd.out_last   = 1'b1;
                n_state          = S_IDLE;
            end else begin
                n_pend  = w_fin_status;
                n_state = S_RESP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

endmodule

>>> bench/tb_array_doubly_linked_list_top.sv
// testbench of the array doubly linked list: queued requests, list predictor, result checks
`timescale 1ns / 1ps

module tb_array_doubly_linked_list_top import adll_pkg::*;;

    localparam int SLOTS  = 64;
    localparam int LINK_W = $clog2(SLOTS);

    // request codes the block has no use for, they must pass without a result
    localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;

    // one item to send, with the idle time in front of it
    typedef struct packed {
        logic [REQ_W-1:0]          op;
        logic [RANK_W-1:0]         rank;
        logic signed [VALUE_W-1:0] value;
        logic [3:0]                gap;
        logic                      drain;   // hold until every result is back
    } t_req;

    // one result item as the block should return it
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [STATUS_W-1:0]       status;
        logic                      last;
    } t_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    adll_req_if req_if ();
    adll_res_if res_if ();

    array_doubly_linked_list_top #(
        .SLOT_COUNT  (SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_chan (req_if),
        .o_res_chan (res_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the list: values, links both ways, live flags, allocator
    logic signed [VALUE_W-1:0] node_val [SLOTS];
    logic [LINK_W-1:0]         left_of  [SLOTS];
    logic [LINK_W-1:0]         right_of [SLOTS];
    bit                        alive    [SLOTS];
    int                        next_slot;

    t_req    req_backlog [$];
    t_result pending_results [$];

    int unsigned issued_reqs;
    int unsigned taken_reqs;
    int unsigned taken_results;
    int unsigned seen_results;
    int          errors;

    // sender side
    int          gap_left;
    bit          gap_armed;
    bit          drive_next;
    t_req        nxt_req;

    // receiver side
    int          stall_left;
    bit          rx_calm;

    // stimulus shaping
    bit          burst;
    bit          drain_next;
    int          inserts_queued;

    initial begin
        foreach (node_val[i]) begin
            node_val[i] = '0;
            left_of[i]  = '0;
            right_of[i] = '0;
            alive[i]    = 1'b0;
        end
        right_of[HEAD_SLOT] = LINK_W'(TAIL_SLOT);
        left_of[TAIL_SLOT]  = LINK_W'(HEAD_SLOT);
        next_slot = FIRST_FREE;
    end

    // expected result goes to the back of the line
    function automatic void post(logic signed [VALUE_W-1:0] v, logic [STATUS_W-1:0] s,
                                 logic l);
        t_result r;
        r.value  = v;
        r.status = s;
        r.last   = l;
        pending_results.push_back(r);
    endfunction

    // new node to the right of anchor, taking the next slot in order
    function automatic logic [STATUS_W-1:0] hang_after(int anchor,
                                                       logic signed [VALUE_W-1:0] v);
        int fresh;
        int nxt;
        if (next_slot >= SLOTS) return ST_FULL;
        fresh           = next_slot;
        nxt             = right_of[anchor];
        node_val[fresh] = v;
        right_of[fresh] = LINK_W'(nxt);
        left_of[fresh]  = LINK_W'(anchor);
        left_of[nxt]    = LINK_W'(fresh);
        right_of[anchor] = LINK_W'(fresh);
        alive[fresh]    = 1'b1;
        next_slot       = next_slot + 1;
        return ST_OK;
    endfunction

    // slot of the k-th inserted node while it is alive, else SLOTS
    function automatic int live_slot(logic [RANK_W-1:0] rank);
        int s;
        s = int'(rank) + 1;
        if (s < FIRST_FREE || s >= SLOTS || s >= next_slot) return SLOTS;
        if (!alive[s]) return SLOTS;
        return s;
    endfunction

    // update the shadow list for one accepted item and queue what it must return
    function automatic void apply_request(logic [REQ_W-1:0] op, logic [RANK_W-1:0] rank,
                                          logic signed [VALUE_W-1:0] v);
        int s;
        int cur;
        int nxt;
        int n;
        case (op)
            REQ_PUSH_FRONT: begin
                post('0, hang_after(HEAD_SLOT, v), 1'b1);
            end
            REQ_PUSH_BACK: begin
                post('0, hang_after(left_of[TAIL_SLOT], v), 1'b1);
            end
            REQ_DELETE: begin
                s = live_slot(rank);
                if (s == SLOTS) begin
                    post('0, ST_DEAD, 1'b1);
                end else begin
                    right_of[left_of[s]] = right_of[s];
                    left_of[right_of[s]] = left_of[s];
                    alive[s] = 1'b0;
                    post('0, ST_OK, 1'b1);
                end
            end
            REQ_INS_LEFT, REQ_INS_RIGHT: begin
                // dead node check wins over the full check
                s = live_slot(rank);
                if (s == SLOTS) begin
                    post('0, ST_DEAD, 1'b1);
                end else begin
                    post('0, hang_after(op == REQ_INS_LEFT ? int'(left_of[s]) : s, v), 1'b1);
                end
            end
            REQ_READ_OUT: begin
                cur = right_of[HEAD_SLOT];
                if (cur == TAIL_SLOT) begin
                    post('0, ST_EMPTY, 1'b1);
                end else begin
                    n = 0;
                    while (cur != TAIL_SLOT && cur != HEAD_SLOT && n < SLOTS - 2) begin
                        nxt = right_of[cur];
                        n++;
                        post(node_val[cur], ST_OK,
                             nxt == TAIL_SLOT || nxt == HEAD_SLOT || n == SLOTS - 2);
                        cur = nxt;
                    end
                end
            end
            default: ;  // spare codes leave no trace
        endcase
    endfunction

    // queue one item, idle time drawn here
    task automatic add_req(logic [REQ_W-1:0] op, int rank, logic [VALUE_W-1:0] v);
        t_req r;
        r.op    = op;
        r.rank  = RANK_W'(rank);
        r.value = v;
        r.gap   = burst ? 4'd0 : 4'($urandom_range(0, 15));
        r.drain = drain_next;
        drain_next = 1'b0;
        if ($urandom_range(0, 19) == 0) burst = !burst;
        if (op == REQ_PUSH_FRONT || op == REQ_PUSH_BACK || op == REQ_INS_LEFT ||
            op == REQ_INS_RIGHT) inserts_queued++;
        req_backlog.push_back(r);
    endtask

    // rank mostly among those likely handed out so far, sometimes anything
    function automatic int pick_rank();
        int hi;
        hi = inserts_queued < 1 ? 1 : (inserts_queued > 62 ? 62 : inserts_queued);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 63);
        return $urandom_range(1, hi);
    endfunction

    // random data, with the sign extremes now and then
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // accept side: items in, results out, all sampled at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                apply_request(req_if.req_type, req_if.node_rank, req_if.item_value);
                taken_reqs++;
            end
            if (res_if.valid && res_if.ready) begin
                taken_results++;
                if (pending_results.size() == 0) begin
                    $error("unexpected result: read_value %0d, status %0d, last %0d",
                           res_if.read_value, res_if.status, res_if.last);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    if (res_if.read_value !== want.value) begin
                        $error("read_value: expected %0d, got %0d", want.value,
                               res_if.read_value);
                        errors++;
                    end
                    if (res_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_if.status);
                        errors++;
                    end
                    if (res_if.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, res_if.last);
                        errors++;
                    end
                end
            end
        end
    end

    // sender: one item at a time from the backlog, changes at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!(req_if.valid && taken_reqs < issued_reqs)) begin
            // nothing on the bus that still waits for acceptance
            drive_next = 1'b0;
            if (req_backlog.size() != 0) begin
                if (!gap_armed) begin
                    gap_left  = req_backlog[0].gap;
                    gap_armed = 1'b1;
                end
                if (req_backlog[0].drain && pending_results.size() != 0) begin
                    // let the block run dry first
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    nxt_req = req_backlog.pop_front();
                    req_if.req_type   <= nxt_req.op;
                    req_if.node_rank  <= nxt_req.rank;
                    req_if.item_value <= nxt_req.value;
                    drive_next = 1'b1;
                    gap_armed  = 1'b0;
                    issued_reqs++;
                end
            end
            // valid stays high across back to back items, one assignment per edge
            req_if.valid <= drive_next;
        end
    end

    // receiver: after each result a random stall, with calm stretches
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (taken_results != seen_results) begin
                seen_results = taken_results;
                stall_left   = rx_calm ? 0 : $urandom_range(0, 15);
                if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int order [62];
        int j;
        int tmp;
        int pick;

        req_if.valid      = 1'b0;
        req_if.req_type   = '0;
        req_if.node_rank  = '0;
        req_if.item_value = '0;
        res_if.ready      = 1'b0;

        // directed: empty list, dead ranks, spare codes, edges of the list
        add_req(REQ_READ_OUT,   0, 32'h0);          // nothing stored yet
        add_req(REQ_DELETE,     0, 32'h0);          // tail sentinel slot
        add_req(REQ_DELETE,    63, 32'h0);          // rank beyond the store
        add_req(REQ_INS_LEFT,   5, 32'h1234_5678);  // never handed out
        add_req(REQ_SPARE6,    21, 32'hFFFF_FFFF);
        add_req(REQ_SPARE7,    42, 32'h0);
        add_req(REQ_PUSH_FRONT, 0, 32'h7FFF_FFFF);  // rank 1
        add_req(REQ_PUSH_BACK, 63, 32'h8000_0000);  // rank 2
        add_req(REQ_PUSH_FRONT, 0, 32'h0);          // rank 3
        add_req(REQ_PUSH_BACK,  0, 32'hFFFF_FFFF);  // rank 4
        add_req(REQ_INS_LEFT,   1, 32'h5555_5555);  // rank 5
        add_req(REQ_INS_RIGHT,  2, 32'hAAAA_AAAA);  // rank 6
        add_req(REQ_INS_RIGHT,  4, 32'h0000_0001);  // rank 7, just before the tail
        add_req(REQ_INS_LEFT,   3, 32'h8000_0001);  // rank 8, just after the head
        add_req(REQ_READ_OUT,   0, 32'h0);
        add_req(REQ_DELETE,     8, 32'h0);          // first node
        add_req(REQ_DELETE,     8, 32'h0);          // already gone
        add_req(REQ_INS_RIGHT,  8, 32'h0F0F_0F0F);  // insert next to a gone node
        add_req(REQ_DELETE,     7, 32'h0);          // last node
        add_req(REQ_DELETE,    62, 32'h0);          // in range but never handed out
        add_req(REQ_READ_OUT,   0, 32'h0);

        // random, mostly growing, until the store runs full
        drain_next = 1'b1;
        for (int i = 0; i < 200; i++) begin
            if ($urandom_range(0, 32) == 0) drain_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 20)      add_req(REQ_PUSH_FRONT, $urandom_range(0, 63), pick_value());
            else if (pick < 40) add_req(REQ_PUSH_BACK, $urandom_range(0, 63), pick_value());
            else if (pick < 55) add_req(REQ_INS_LEFT, pick_rank(), pick_value());
            else if (pick < 70) add_req(REQ_INS_RIGHT, pick_rank(), pick_value());
            else if (pick < 80) add_req(REQ_DELETE, pick_rank(), pick_value());
            else if (pick < 93) add_req(REQ_READ_OUT, $urandom_range(0, 63), pick_value());
            else if (pick < 97) add_req(REQ_SPARE6, $urandom_range(0, 63), pick_value());
            else                add_req(REQ_SPARE7, $urandom_range(0, 63), pick_value());
        end

        // shrinking: every rank deleted once in shuffled order, so the list empties
        foreach (order[i]) order[i] = i + 1;
        for (int i = 61; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        drain_next = 1'b1;
        foreach (order[i]) begin
            add_req(REQ_DELETE, order[i], pick_value());
            if ($urandom_range(0, 9) < 3) begin
                pick = $urandom_range(0, 9);
                if (pick < 5)      add_req(REQ_READ_OUT, 0, pick_value());
                else if (pick < 7) add_req(REQ_INS_LEFT, pick_rank(), pick_value());
                else if (pick < 9) add_req(REQ_PUSH_BACK, 0, pick_value());
                else               add_req(REQ_DELETE, pick_rank(), pick_value());
            end
        end
        add_req(REQ_READ_OUT,   0, 32'h0);          // empty again after deletions
        add_req(REQ_INS_RIGHT,  1, 32'h0);
        add_req(REQ_PUSH_FRONT, 0, 32'h0);

        // synchronous reset, released away from the sampling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() != 0 || taken_reqs != issued_reqs) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        // room for anything stray after the last result
        repeat (20) @(posedge i_clk);

        if (errors == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // run limit far above the slowest legal run
    initial begin
        #30_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> array_doubly_linked_list_top.f
hw/rtl/adll_pkg.sv
hw/rtl/adll_if.sv
hw/rtl/adll_ram.sv
hw/rtl/adll_dp.sv
hw/rtl/adll_ctrl.sv
hw/rtl/array_doubly_linked_list_top.sv
bench/tb_array_doubly_linked_list_top.sv
